// File: src/qfr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and stage types for the quaternion frame rotator.
// Depends on nothing; every other file uses it.
package qfr_pkg;

    localparam int QW     = 16;   // quaternion component width
    localparam int VW     = 32;   // vector component width
    localparam int PRW    = 32;   // width of a quaternion product
    localparam int SW     = 33;   // squared norm, unsigned
    localparam int RW     = 34;   // matrix numerator, signed
    localparam int PW     = RW + VW;  // one row term
    localparam int AW     = PW + 2;   // row sum
    localparam int NW     = 67;   // rounding numerator 2*|sum| + s
    localparam int DW     = SW + 1;   // divisor 2*s
    localparam int QBITS  = NW - DW;  // quotient bits, one per divide stage
    localparam int FW     = 15;   // floor register width
    localparam int FSW    = 2 * FW;

    localparam logic OP_TO_BODY  = 1'b0;
    localparam logic OP_TO_WORLD = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_QUAT = 1'b1;

    localparam logic [QBITS-1:0] NEG_LIMIT = QBITS'(64'h8000_0000);
    localparam logic [QBITS-1:0] POS_LIMIT = QBITS'(64'h7FFF_FFFF);
    localparam logic [VW-1:0]    SAT_NEG   = 32'h8000_0000;
    localparam logic [VW-1:0]    SAT_POS   = 32'h7FFF_FFFF;

    typedef logic signed [RW-1:0] mat_elem_t;
    typedef mat_elem_t [2:0][2:0] mat_t;
    typedef logic signed [VW-1:0] vec_elem_t;
    typedef vec_elem_t [2:0] vec_t;

    typedef struct packed {
        logic signed [PRW-1:0] ww;
        logic signed [PRW-1:0] xx;
        logic signed [PRW-1:0] yy;
        logic signed [PRW-1:0] zz;
        logic signed [PRW-1:0] xy;
        logic signed [PRW-1:0] zw;
        logic signed [PRW-1:0] xz;
        logic signed [PRW-1:0] yw;
        logic signed [PRW-1:0] yz;
        logic signed [PRW-1:0] xw;
    } quat_prod_t;

    typedef struct packed {
        logic [2:0][NW-1:0] work;
        logic [2:0]         neg;
        logic [DW-1:0]      den;
        logic               inval;
    } div_t;

    function automatic mat_elem_t sx_prod(input logic signed [PRW-1:0] a);
        return {{(RW-PRW){a[PRW-1]}}, a};
    endfunction

endpackage

// File: src/qfr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for item and result words.
// Depends on qfr_pkg for field widths.
interface qfr_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic signed [qfr_pkg::QW-1:0]   quat_w;
    logic signed [qfr_pkg::QW-1:0]   quat_x;
    logic signed [qfr_pkg::QW-1:0]   quat_y;
    logic signed [qfr_pkg::QW-1:0]   quat_z;
    logic signed [qfr_pkg::VW-1:0]   in_x;
    logic signed [qfr_pkg::VW-1:0]   in_y;
    logic signed [qfr_pkg::VW-1:0]   in_z;

    modport source (output valid, op, quat_w, quat_x, quat_y, quat_z, in_x, in_y, in_z,
                    input ready);
    modport sink   (input valid, op, quat_w, quat_x, quat_y, quat_z, in_x, in_y, in_z,
                    output ready);
endinterface

interface qfr_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [qfr_pkg::VW-1:0]   out_x;
    logic signed [qfr_pkg::VW-1:0]   out_y;
    logic signed [qfr_pkg::VW-1:0]   out_z;
    logic                            status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// File: src/qfr_quat_prod.sv
`timescale 1ns / 1ps
// First stage: all ten pairwise quaternion products, registered.
// Depends on qfr_pkg.
module qfr_quat_prod (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [qfr_pkg::QW-1:0] w,
    input  logic signed [qfr_pkg::QW-1:0] x,
    input  logic signed [qfr_pkg::QW-1:0] y,
    input  logic signed [qfr_pkg::QW-1:0] z,
    output qfr_pkg::quat_prod_t           prod_reg
);
    import qfr_pkg::*;

    quat_prod_t prod_next;

    always_comb
    begin
        prod_next.ww = w * w;
        prod_next.xx = x * x;
        prod_next.yy = y * y;
        prod_next.zz = z * z;
        prod_next.xy = x * y;
        prod_next.zw = z * w;
        prod_next.xz = x * z;
        prod_next.yw = y * w;
        prod_next.yz = y * z;
        prod_next.xw = x * w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end
endmodule

// File: src/qfr_matrix.sv
`timescale 1ns / 1ps
// Second stage: squared norm, floor check and rotation matrix numerators.
// Depends on qfr_pkg.
module qfr_matrix (
    input  logic                      clk,
    input  logic                      en,
    input  qfr_pkg::quat_prod_t       prod,
    input  logic [qfr_pkg::FSW-1:0]   floor_sq,
    output logic [qfr_pkg::SW-1:0]    s_reg,
    output qfr_pkg::mat_t             mat_reg,
    output logic                      inval_reg
);
    import qfr_pkg::*;

    logic [SW-1:0] s_next;
    mat_t          mat_next;
    logic          inval_next;
    mat_elem_t     ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;

    always_comb
    begin
        ww = sx_prod(prod.ww);
        xx = sx_prod(prod.xx);
        yy = sx_prod(prod.yy);
        zz = sx_prod(prod.zz);
        xy = sx_prod(prod.xy);
        zw = sx_prod(prod.zw);
        xz = sx_prod(prod.xz);
        yw = sx_prod(prod.yw);
        yz = sx_prod(prod.yz);
        xw = sx_prod(prod.xw);

        // squares are never negative, so the low bits are the magnitude
        s_next = {1'b0, prod.ww} + {1'b0, prod.xx} + {1'b0, prod.yy} + {1'b0, prod.zz};
        inval_next = (s_next == '0) || (s_next < SW'(floor_sq));

        mat_next[0][0] = ww + xx - yy - zz;
        mat_next[0][1] = (xy - zw) <<< 1;
        mat_next[0][2] = (xz + yw) <<< 1;
        mat_next[1][0] = (xy + zw) <<< 1;
        mat_next[1][1] = ww - xx + yy - zz;
        mat_next[1][2] = (yz - xw) <<< 1;
        mat_next[2][0] = (xz - yw) <<< 1;
        mat_next[2][1] = (yz + xw) <<< 1;
        mat_next[2][2] = ww - xx - yy + zz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= s_next;
            mat_reg   <= mat_next;
            inval_reg <= inval_next;
        end
    end
endmodule

// File: src/qfr_row_mac.sv
`timescale 1ns / 1ps
// Three stages for one output row: products, sum, then sign and the
// rounding numerator 2*|sum| + s. Depends on qfr_pkg.
module qfr_row_mac (
    input  logic                          clk,
    input  logic                          en,
    input  qfr_pkg::mat_elem_t [2:0]      row,
    input  qfr_pkg::vec_t                 vec,
    input  logic [qfr_pkg::SW-1:0]        s,
    output logic [qfr_pkg::NW-1:0]        num_reg,
    output logic                          neg_reg
);
    import qfr_pkg::*;

    logic signed [PW-1:0] prod_reg [3];
    logic signed [PW-1:0] prod_next [3];
    logic [SW-1:0]        s1_reg, s2_reg;
    logic signed [AW-1:0] sum_reg, sum_next;
    logic [AW-1:0]        mag;
    logic [NW-1:0]        num_next;
    logic                 neg_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod_next[j] = $signed(row[j]) * $signed(vec[j]);
        end
        sum_next = AW'(prod_reg[0]) + AW'(prod_reg[1]) + AW'(prod_reg[2]);
        neg_next = sum_reg[AW-1];
        mag      = neg_next ? AW'(-sum_reg) : AW'(sum_reg);
        num_next = {mag[NW-2:0], 1'b0} + NW'(s2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
            s1_reg  <= s;
            sum_reg <= sum_next;
            s2_reg  <= s1_reg;
            num_reg <= num_next;
            neg_reg <= neg_next;
        end
    end
endmodule

// File: src/qfr_div_step.sv
`timescale 1ns / 1ps
// One restoring divide stage: one quotient bit for each of the three rows.
// Depends on qfr_pkg.
module qfr_div_step (
    input  logic          clk,
    input  logic          en,
    input  qfr_pkg::div_t div_in,
    output qfr_pkg::div_t div_reg
);
    import qfr_pkg::*;

    div_t          div_next;
    logic [DW:0]   trial [3];
    logic [DW:0]   diff  [3];
    logic          take  [3];

    always_comb
    begin
        div_next = div_in;
        for (int i = 0; i < 3; i++)
        begin
            // shift the next numerator bit into the partial remainder
            trial[i] = {div_in.work[i][NW-1:QBITS], div_in.work[i][QBITS-1]};
            diff[i]  = trial[i] - {1'b0, div_in.den};
            take[i]  = trial[i] >= {1'b0, div_in.den};
            div_next.work[i] = {take[i] ? diff[i][DW-1:0] : trial[i][DW-1:0],
                                div_in.work[i][QBITS-2:0], take[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end
endmodule

// File: src/quaternion_frame_rotate.sv
`timescale 1ns / 1ps
// Quaternion frame rotator: rotates a Q15.16 vector by a Q1.14 attitude
// quaternion, normalized exactly, rounded to nearest and saturated.
//
// Channels: din takes one word per item (op, quaternion, vector); dout
// gives one word per item (rotated vector, status). op = 1 rotates body
// to world, op = 0 world to body with the transposed matrix. A quaternion
// whose squared norm is zero or below norm_floor^2 returns a zero vector
// and status 1.
// Configuration: cfg_we/cfg_wdata write norm_floor; write only while idle.
// Pipeline: from acceptance to the result word an item passes one product stage,
// one matrix stage, three row multiply-accumulate stages, 33 divide stages
// (one quotient bit each for the exact division by the squared norm) and
// one saturation/output register.
// Throughput: one word per cycle while dout is not stalled; every stage advances together.
// Stall: while a result waits on dout, the whole pipeline holds and
// din.ready drops; nothing is lost or repeated. Empty slots move forward
// whenever the output register is free or being read.
// Reset: all valid bits clear, norm_floor returns to 1.
module quaternion_frame_rotate (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [qfr_pkg::FW-1:0]   cfg_wdata,
    qfr_in_if.sink                   din,
    qfr_out_if.source                dout
);
    import qfr_pkg::*;

    localparam int LAT = 2 + 3 + QBITS + 1;

    // configuration and precomputed floor square
    logic [FW-1:0]  norm_floor_reg;
    logic [FSW-1:0] floor_sq_reg;

    // pipeline control
    logic           adv;
    logic [LAT-1:0] valid_reg, valid_next;

    // sideband data for the first two stages
    logic           op_a_reg, op_b_reg;
    vec_t           vec_a_reg, vec_b_reg;

    quat_prod_t     prod;
    logic [SW-1:0]  s_b;
    mat_t           mat_b;
    logic           inval_b;

    // aligned with the row mac outputs
    logic [SW-1:0]  s_dly_reg [3];
    logic           inval_dly_reg [3];
    logic [NW-1:0]  num [3];
    logic           neg [3];

    div_t           div_chain [QBITS+1];

    logic [VW-1:0]  res_next [3];
    logic           status_reg;
    logic [VW-1:0]  res_reg [3];

    // Advance when the output register is empty or being drained.
    assign adv       = !valid_reg[LAT-1] || dout.ready;
    assign din.ready = adv;
    assign valid_next = {valid_reg[LAT-2:0], din.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_floor_reg <= FW'(1);
            floor_sq_reg   <= FSW'(1);
            valid_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                norm_floor_reg <= cfg_wdata;
            end
            floor_sq_reg <= norm_floor_reg * norm_floor_reg;
            if (adv)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    // Stage A: quaternion products.
    qfr_quat_prod u_prod (
        .clk      (clk),
        .en       (adv),
        .w        (din.quat_w),
        .x        (din.quat_x),
        .y        (din.quat_y),
        .z        (din.quat_z),
        .prod_reg (prod)
    );

    // Stage B: norm, floor test, matrix.
    qfr_matrix u_matrix (
        .clk       (clk),
        .en        (adv),
        .prod      (prod),
        .floor_sq  (floor_sq_reg),
        .s_reg     (s_b),
        .mat_reg   (mat_b),
        .inval_reg (inval_b)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_a_reg  <= din.op;
            vec_a_reg <= '{din.in_z, din.in_y, din.in_x};
            op_b_reg  <= op_a_reg;
            vec_b_reg <= vec_a_reg;
            s_dly_reg[0]     <= s_b;
            inval_dly_reg[0] <= inval_b;
            for (int k = 1; k < 3; k++)
            begin
                s_dly_reg[k]     <= s_dly_reg[k-1];
                inval_dly_reg[k] <= inval_dly_reg[k-1];
            end
        end
    end

    // Stages C to E: one multiply-accumulate per output row. The transpose
    // for world to body just swaps the matrix indexes.
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        mat_elem_t [2:0] row_sel;

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                row_sel[j] = (op_b_reg == OP_TO_WORLD) ? mat_b[i][j] : mat_b[j][i];
            end
        end

        qfr_row_mac u_mac (
            .clk     (clk),
            .en      (adv),
            .row     (row_sel),
            .vec     (vec_b_reg),
            .s       (s_b),
            .num_reg (num[i]),
            .neg_reg (neg[i])
        );

        assign div_chain[0].work[i] = num[i];
        assign div_chain[0].neg[i]  = neg[i];
    end

    assign div_chain[0].den   = {s_dly_reg[2], 1'b0};
    assign div_chain[0].inval = inval_dly_reg[2];

    // Divide stages: one quotient bit per stage, most significant first.
    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        qfr_div_step u_step (
            .clk     (clk),
            .en      (adv),
            .div_in  (div_chain[k]),
            .div_reg (div_chain[k+1])
        );
    end

    // Output stage: apply sign, saturate, or drop to zero when rejected.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QBITS-1:0] q;
            q = div_chain[QBITS].work[i][QBITS-1:0];
            if (div_chain[QBITS].inval)
            begin
                res_next[i] = '0;
            end
            else if (div_chain[QBITS].neg[i])
            begin
                res_next[i] = (q > NEG_LIMIT) ? SAT_NEG : VW'(-q);
            end
            else
            begin
                res_next[i] = (q > POS_LIMIT) ? SAT_POS : q[VW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            status_reg <= div_chain[QBITS].inval ? STATUS_BAD_QUAT : STATUS_OK;
        end
    end

    assign dout.valid  = valid_reg[LAT-1];
    assign dout.out_x  = res_reg[0];
    assign dout.out_y  = res_reg[1];
    assign dout.out_z  = res_reg[2];
    assign dout.status = status_reg;

`ifndef SYNTHESIS
    // A rejected quaternion always leaves a zero vector.
    a_bad_quat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (dout.status == STATUS_BAD_QUAT) |->
            dout.out_x == '0 && dout.out_y == '0 && dout.out_z == '0)
        else $error("rejected quaternion with nonzero result");

    // While the output stalls, no slot moves.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    // An accepted word occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> valid_reg[0])
        else $error("accepted word lost at entry");
`endif
endmodule
